>>> design/ssid_pkg.sv
// Shared types and codes for the sorted set insert/delete unit.
// No dependencies; imported by every module of the block.
package ssid_pkg;

    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 3;
    localparam int OUT_W    = 6;

    typedef logic signed [VALUE_W-1:0] t_value;
    typedef logic [STATUS_W-1:0]       t_status;

    localparam logic OP_ADD = 1'b0;
    localparam logic OP_DEL = 1'b1;

    localparam t_status ST_ADDED    = 3'd0;
    localparam t_status ST_PRESENT  = 3'd1;
    localparam t_status ST_DELETED  = 3'd2;
    localparam t_status ST_NOTFOUND = 3'd3;
    localparam t_status ST_FULL     = 3'd4;

    // Control broadcast from the sequencer to every cell of the chain.
    typedef struct packed {
        logic   latch;   // capture compare flags against key
        logic   ins;     // shift up and insert key
        logic   del;     // shift down over the matching entry
        t_value key;
    } t_cell_ctl;

endpackage

>>> design/ssid_cell.sv
// One storage cell of the sorted chain: a value and its compare flags.
// Depends on ssid_pkg.
module ssid_cell
    import ssid_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  logic      i_occupied,
    input  t_value    i_left_value,
    input  logic      i_left_lt,
    input  t_value    i_right_value,
    output t_value    o_value,
    output logic      o_lt,
    output logic      o_eq
);

    t_value r_value;
    logic   r_lt;
    logic   r_eq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lt <= 1'b0;
            r_eq <= 1'b0;
        end else if (i_ctl.latch) begin
            r_lt <= i_occupied && ($signed(r_value) < $signed(i_ctl.key));
            r_eq <= i_occupied && (r_value == i_ctl.key);
        end
    end

    // Entries below the key hold; the rest shift toward the free slot.
    always_ff @(posedge i_clk) begin
        if (i_ctl.ins && !r_lt) begin
            r_value <= i_left_lt ? i_ctl.key : i_left_value;
        end else if (i_ctl.del && !r_lt) begin
            r_value <= i_right_value;
        end
    end

    assign o_value = r_value;
    assign o_lt    = r_lt;
    assign o_eq    = r_eq;

endmodule

>>> design/ssid_chain.sv
// Row of ssid_cell instances wired to their neighbors, with occupancy
// derived from the fill count. Depends on ssid_pkg and ssid_cell.
module ssid_chain
    import ssid_pkg::*;
#(
    parameter int CAPACITY = 32,
    parameter int CW       = $clog2(CAPACITY + 1)
)
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cell_ctl           i_ctl,
    input  logic [CW-1:0]       i_count,
    output logic [CAPACITY-1:0] o_lt,
    output logic [CAPACITY-1:0] o_eq
);

    t_value values [CAPACITY];

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic   occupied;
        t_value left_value;
        logic   left_lt;
        t_value right_value;

        assign occupied = i_count > CW'(g);

        if (g == 0) begin : g_first
            // Cell 0 sees a "below key" neighbor so it takes the key.
            assign left_value = i_ctl.key;
            assign left_lt    = 1'b1;
        end else begin : g_mid
            assign left_value = values[g-1];
            assign left_lt    = o_lt[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign right_value = values[g];
        end else begin : g_notlast
            assign right_value = values[g+1];
        end

        ssid_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (i_ctl),
            .i_occupied    (occupied),
            .i_left_value  (left_value),
            .i_left_lt     (left_lt),
            .i_right_value (right_value),
            .o_value       (values[g]),
            .o_lt          (o_lt[g]),
            .o_eq          (o_eq[g])
        );
    end

endmodule

>>> design/sorted_set_insert_delete_unit.sv
// Top level of the sorted set insert/delete unit: sequencer, position
// search, fill count and output register. Depends on ssid_pkg, ssid_chain.
//
// Usage
//   Input channel: i_in_valid / o_in_stall with i_op (0 add, 1 delete) and
//   i_value (signed 32 bits). An item is taken at a rising edge with
//   i_in_valid high and o_in_stall low.
//   Output channel: o_out_valid / i_out_stall with o_status, o_position
//   and o_count, one result item per input item, in order.
//   Values live in a chain of CAPACITY cells, ascending from cell 0. Each
//   item runs: a capture of the key, a step in which every cell compares
//   itself with the key, a binary search over the cells' "below key"
//   flags (one position bit a cycle), and a final step in which the status
//   is decided and, for a successful add or delete, the cells at and above
//   the position shift one place at once. The result is registered in the
//   final step, and the next item is taken only once the sequencer is back
//   in idle, so items do not overlap; the search length sets the spacing.
//   A finished result sits in the output register while the next item is
//   accepted. If the receiver stalls and the register is still full when
//   the next result is ready, the sequencer holds in its final step and
//   leaves the cells untouched until the slot frees.
//   Reset (i_rst_n low, synchronous) empties the set by clearing the count;
//   cell contents are left as they are and never read before rewritten.
module sorted_set_insert_delete_unit
    import ssid_pkg::*;
#(
    parameter int CAPACITY = 32
)
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_op,
    input  logic signed [31:0]  i_value,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [2:0]          o_status,
    output logic [5:0]          o_position,
    output logic [5:0]          o_count
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam logic [CW-1:0] CAP_C    = CW'(CAPACITY);
    localparam logic [CW-1:0] MASK_TOP = {1'b1, {(CW-1){1'b0}}};

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_SRCH = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0]          r_state;
    logic                r_op;
    t_value              r_key;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       r_pos;
    logic [CW-1:0]       r_mask;

    logic                r_out_valid;
    t_status             r_status;
    logic [OUT_W-1:0]    r_position;
    logic [OUT_W-1:0]    r_count_out;

    logic [CAPACITY-1:0] lt_vec;
    logic [CAPACITY-1:0] eq_vec;
    t_cell_ctl           cell_ctl;

    logic                in_take;
    logic                out_free;
    logic [CW-1:0]       cand;
    logic                step_take;
    logic                hit;
    logic                full;
    logic                fin_go;
    logic                do_ins;
    logic                do_del;
    t_status             fin_status;
    logic [CW-1:0]       n_count;

    assign in_take  = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    // Binary search on the thermometer of "below key" flags.
    assign cand      = r_pos | r_mask;
    assign step_take = (cand <= CAP_C) && lt_vec[IW'(cand - 1'b1)];

    // Final step: decide status and the chain action.
    assign hit    = (r_pos < CAP_C) && eq_vec[IW'(r_pos)];
    assign full   = (r_count == CAP_C);
    assign fin_go = (r_state == S_FIN) && out_free;
    assign do_ins = fin_go && (r_op == OP_ADD) && !hit && !full;
    assign do_del = fin_go && (r_op == OP_DEL) && hit;

    always_comb begin
        fin_status = ST_NOTFOUND;
        n_count    = r_count;
        if (r_op == OP_ADD) begin
            if (hit) begin
                fin_status = ST_PRESENT;
            end else if (full) begin
                fin_status = ST_FULL;
            end else begin
                fin_status = ST_ADDED;
                n_count    = r_count + 1'b1;
            end
        end else begin
            if (hit) begin
                fin_status = ST_DELETED;
                n_count    = r_count - 1'b1;
            end
        end
    end

    assign cell_ctl.latch = (r_state == S_CMP);
    assign cell_ctl.ins   = do_ins;
    assign cell_ctl.del   = do_del;
    assign cell_ctl.key   = r_key;

    ssid_chain #(
        .CAPACITY (CAPACITY),
        .CW       (CW)
    ) u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (cell_ctl),
        .i_count (r_count),
        .o_lt    (lt_vec),
        .o_eq    (eq_vec)
    );

    // Sequencer and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pos   <= '0;
            r_mask  <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    r_pos   <= '0;
                    r_mask  <= MASK_TOP;
                    r_state <= S_SRCH;
                end
                S_SRCH: begin
                    if (step_take) begin
                        r_pos <= cand;
                    end
                    r_mask <= r_mask >> 1;
                    if (r_mask[0]) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    // Hold until the output slot frees.
                    if (out_free) begin
                        r_count <= n_count;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Capture the item.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_op  <= i_op;
            r_key <= i_value;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fin_go) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_go) begin
            r_status    <= fin_status;
            r_position  <= OUT_W'(r_pos);
            r_count_out <= OUT_W'(n_count);
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_position  = r_position;
    assign o_count     = r_count_out;

endmodule

>>> verif/ssid_checker.sv
// Checker for the sorted set insert/delete unit: watches both channels, predicts each result
// from its own copy of the set and compares it with what the block returns.
// Depends on ssid_pkg.
module ssid_checker
    import ssid_pkg::*;
#(
    parameter int CAPACITY = 32
)
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic               i_op,
    input  logic signed [31:0] i_value,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [2:0]         i_status,
    input  logic [5:0]         i_position,
    input  logic [5:0]         i_count,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_checked,
    output int                 o_full_hits
);

    typedef struct packed {
        t_status          status;
        logic [OUT_W-1:0] position;
        logic [OUT_W-1:0] count;
    } t_set_result;

    t_value      set_values [CAPACITY];
    int unsigned set_fill;
    t_set_result expected_results [$];
    int          fail_cnt;
    int          checked_cnt;
    int          full_cnt;

    initial begin
        set_fill     = 0;
        fail_cnt     = 0;
        checked_cnt  = 0;
        full_cnt     = 0;
    end

    // Apply one add or delete to the mirrored set and return the result it causes.
    function automatic t_set_result apply_set_op(logic op, t_value value);
        t_set_result res;
        int unsigned idx;
        bit          hit;
        idx = 0;
        while (idx < set_fill && set_values[idx] < value)
            idx++;
        hit = (idx < set_fill) && (set_values[idx] == value);
        if (op == OP_ADD) begin
            if (hit) begin
                res.status = ST_PRESENT;
            end else if (set_fill >= CAPACITY) begin
                res.status = ST_FULL;
            end else begin
                for (int j = set_fill; j > idx; j--)
                    set_values[j] = set_values[j-1];
                set_values[idx] = value;
                set_fill++;
                res.status = ST_ADDED;
            end
        end else begin
            if (hit) begin
                for (int j = idx; j + 1 < set_fill; j++)
                    set_values[j] = set_values[j+1];
                set_fill--;
                res.status = ST_DELETED;
            end else begin
                res.status = ST_NOTFOUND;
            end
        end
        res.position = OUT_W'(idx);
        res.count    = OUT_W'(set_fill);
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_set_result want;
        if (!i_rst_n) begin
            set_fill = 0;
            expected_results.delete();
        end else begin
            // Compare a delivered result first; it always belongs to an older item.
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result with nothing expected: status %0d position %0d count %0d",
                             $time, i_status, i_position, i_count);
                    fail_cnt++;
                end else begin
                    want = expected_results.pop_front();
                    checked_cnt++;
                    if (want.status == ST_FULL)
                        full_cnt++;
                    if (i_status !== want.status) begin
                        $display("%0t: status mismatch: expected %0d actual %0d",
                                 $time, want.status, i_status);
                        fail_cnt++;
                    end
                    if (i_position !== want.position) begin
                        $display("%0t: position mismatch: expected %0d actual %0d",
                                 $time, want.position, i_position);
                        fail_cnt++;
                    end
                    if (i_count !== want.count) begin
                        $display("%0t: count mismatch: expected %0d actual %0d",
                                 $time, want.count, i_count);
                        fail_cnt++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_results.push_back(apply_set_op(i_op, i_value));
        end
        o_fail_count <= fail_cnt;
        o_pending    <= expected_results.size();
        o_checked    <= checked_cnt;
        o_full_hits  <= full_cnt;
    end

endmodule

>>> verif/sorted_set_insert_delete_unit_tb.sv
// Testbench top for the sorted set insert/delete unit: drives add/delete items with random
// idling on both channels and gives the verdict. Depends on ssid_pkg, ssid_checker and the RTL.
module sorted_set_insert_delete_unit_tb;
    import ssid_pkg::*;

    localparam int CAPACITY     = 32;
    localparam int RANDOM_ITEMS = 1530;
    localparam int PHASE_LEN    = 100;   // items per fill or drain phase
    localparam int QUIET_ITEMS  = 200;   // tail of the run without idling
    localparam int HOLD_AT      = 300;   // random item that starts the long output hold-off
    localparam int PAUSE_AT     = 700;   // random item before which the sender drains the block
    localparam int HOLD_CYCLES  = 80;
    localparam int POOL_SIZE    = 48;    // more than CAPACITY so adds can fill the set
    localparam int HIST_SIZE    = 32;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               i_op        = OP_ADD;
    logic signed [31:0] i_value     = '0;
    logic               i_out_stall = 1'b0;
    logic               o_in_stall;
    logic               o_out_valid;
    logic [2:0]         o_status;
    logic [5:0]         o_position;
    logic [5:0]         o_count;

    // Flags from the sender to the receiver, written with NBAs so the receiver sees them without a race.
    logic quiet_tail    = 1'b0;
    logic long_hold_req = 1'b0;

    int fail_count;
    int pending;
    int checked;
    int full_hits;

    int     sent_cnt = 0;
    int     directed_cnt;
    t_value value_pool [POOL_SIZE];
    t_value fresh_hist [HIST_SIZE];
    int     hist_wr = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    sorted_set_insert_delete_unit #(
        .CAPACITY(CAPACITY)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_op       (i_op),
        .i_value    (i_value),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_status   (o_status),
        .o_position (o_position),
        .o_count    (o_count)
    );

    ssid_checker #(
        .CAPACITY(CAPACITY)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_stall  (o_in_stall),
        .i_op        (i_op),
        .i_value     (i_value),
        .i_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (o_status),
        .i_position  (o_position),
        .i_count     (o_count),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_checked   (checked),
        .o_full_hits (full_hits)
    );

    // Offer one item and hold it until the block takes it; then maybe idle for a short burst.
    task automatic send_item(logic op, t_value value);
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_value    <= value;
        do
            @(posedge i_clk);
        while (o_in_stall);
        sent_cnt++;
        if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    // Draw mostly from a small pool so values repeat (present, deleted, full); sometimes
    // reuse a recent fresh value, sometimes make a fresh one that exercises every bit.
    function automatic t_value pick_value();
        int     roll;
        t_value fresh;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return value_pool[$urandom_range(0, POOL_SIZE-1)];
        if (roll < 85)
            return fresh_hist[$urandom_range(0, HIST_SIZE-1)];
        fresh               = $urandom;
        fresh_hist[hist_wr] = fresh;
        hist_wr             = (hist_wr + 1) % HIST_SIZE;
        return fresh;
    endfunction

    // Receiver: random stall bursts, one long hold-off on request, none in the quiet tail.
    initial begin
        int burst_left;
        int hold_left;
        bit hold_taken;
        burst_left = 0;
        hold_left  = 0;
        hold_taken = 0;
        forever begin
            @(posedge i_clk);
            if (long_hold_req && !hold_taken) begin
                hold_taken = 1;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else if (burst_left > 0) begin
                i_out_stall <= 1'b1;
                burst_left--;
            end else if (!quiet_tail && $urandom_range(0, 6) == 0) begin
                i_out_stall <= 1'b1;
                burst_left = $urandom_range(0, 4);
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Sender: reset, directed corner cases, then alternating fill and drain phases.
    initial begin
        int  wait_cycles;
        bit  filling;
        logic op;
        for (int i = 0; i < POOL_SIZE; i++)
            value_pool[i] = $urandom;
        for (int i = 0; i < HIST_SIZE; i++)
            fresh_hist[i] = $urandom;
        value_pool[0] = 32'sh8000_0000;
        value_pool[1] = 32'sh7FFF_FFFF;
        value_pool[2] = 32'sd0;
        value_pool[3] = -32'sd1;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Delete from the empty set, then build a set around the signed extremes.
        send_item(OP_DEL, 32'sd7);
        send_item(OP_ADD, 32'sd0);
        send_item(OP_ADD, 32'sh8000_0000);
        send_item(OP_ADD, 32'sh7FFF_FFFF);
        send_item(OP_ADD, -32'sd1);
        send_item(OP_ADD, 32'sd1);
        // Re-add stored values: in the middle and at the top.
        send_item(OP_ADD, 32'sd0);
        send_item(OP_ADD, 32'sh7FFF_FFFF);
        // Delete an absent value that falls between stored ones.
        send_item(OP_DEL, 32'sd5);
        // Remove the lowest and the highest, then miss past the end.
        send_item(OP_DEL, 32'sh8000_0000);
        send_item(OP_DEL, 32'sh7FFF_FFFF);
        send_item(OP_DEL, 32'sh7FFF_FFFF);
        send_item(OP_ADD, 32'sh5555_5555);
        send_item(OP_ADD, 32'shAAAA_AAAA);
        send_item(OP_DEL, -32'sd1);
        send_item(OP_DEL, 32'sd0);
        send_item(OP_DEL, 32'sd1);
        send_item(OP_DEL, 32'sh5555_5555);
        send_item(OP_DEL, 32'shAAAA_AAAA);
        send_item(OP_DEL, 32'shAAAA_AAAA);
        directed_cnt = sent_cnt;

        filling = 1;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % PHASE_LEN == 0 && n > 0) begin
                filling = !filling;
                // Swap a few pool entries so the stored values drift over the run.
                repeat (4) value_pool[$urandom_range(4, POOL_SIZE-1)] = $urandom;
            end
            if (n == HOLD_AT)
                long_hold_req <= 1'b1;
            if (n == PAUSE_AT) begin
                // Stop offering and let every outstanding result come back.
                i_in_valid <= 1'b0;
                @(posedge i_clk);
                while (pending != 0)
                    @(posedge i_clk);
            end
            if (n == RANDOM_ITEMS - QUIET_ITEMS)
                quiet_tail <= 1'b1;
            if (filling)
                op = ($urandom_range(0, 99) < 75) ? OP_ADD : OP_DEL;
            else
                op = ($urandom_range(0, 99) < 75) ? OP_DEL : OP_ADD;
            send_item(op, pick_value());
        end
        i_in_valid <= 1'b0;

        // Drain: wait for the outstanding results, then give the block a few more cycles.
        wait_cycles = 0;
        @(posedge i_clk);
        while (pending != 0 && wait_cycles < 5000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (20) @(posedge i_clk);

        if (pending != 0)
            $display("%0d expected results never arrived", pending);
        $display("sent %0d items (%0d directed), checked %0d results, %0d full refusals",
                 sent_cnt, directed_cnt, checked, full_hits);
        $display("covered a long output hold-off and a full drain pause");
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #4000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
